@@ rtl/echk_pkg.sv @@
package echk_pkg;

  // Lattice resolution per axis; the curve distance has twice as many bits.
  localparam int LATTICE_BITS = 15;

  localparam int COORD_W = 32;
  localparam int SUM_W   = COORD_W + 2;
  localparam int CURVE_W = 30;
  localparam int VCNT_W  = 3;
  localparam int CFG_IDX_W = 2;

  // Division by three is done in two halves of the biased sum.
  localparam int HALF_W   = SUM_W / 2;
  localparam int QHI_W    = HALF_W - 1;
  localparam int DIVHI_SH = HALF_W + 2;
  localparam int DIVLO_W  = HALF_W + 2;
  localparam int DIVLO_SH = DIVLO_W + 2;
  localparam logic [HALF_W:0]  DIV3_HI_MUL = (HALF_W + 1)'(((64'd1 << DIVHI_SH) + 2) / 3);
  localparam logic [DIVLO_W:0] DIV3_LO_MUL = (DIVLO_W + 1)'(((64'd1 << DIVLO_SH) + 2) / 3);
  localparam logic [SUM_W-1:0] TRI_BIAS = SUM_W'(64'd3 << (COORD_W - 1));

  localparam logic [COORD_W-1:0] CELL_TOP = COORD_W'((64'd1 << LATTICE_BITS) - 1);

  localparam logic [VCNT_W-1:0]  VERTICES_TRI   = 3'd3;
  localparam logic [VCNT_W-1:0]  VERTICES_RESET = 3'd4;
  localparam logic [COORD_W-1:0] SCALE_RESET    = 32'd65536;

  localparam int LAT_STAGES = 7;
  localparam int HIL_STEPS  = 4;
  localparam int HIL_STAGES = (LATTICE_BITS + HIL_STEPS - 1) / HIL_STEPS;
  localparam int PIPE_DEPTH = LAT_STAGES + HIL_STAGES;
  localparam int FLIGHT_W   = $clog2(PIPE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VERTICES_USED = 2'd0,
    REG_BOX_MIN_X     = 2'd1,
    REG_BOX_MIN_Y     = 2'd2,
    REG_LATTICE_SCALE = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                      quad;
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] min_y;
    logic        [COORD_W-1:0] scale;
  } cfg_t;

  typedef struct packed {
    logic [LATTICE_BITS-1:0] x;
    logic [LATTICE_BITS-1:0] y;
    logic                    clamped;
  } lat_pt_t;

endpackage

@@ rtl/echk_lattice.sv @@
module echk_lattice import echk_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  cfg_t                      cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] vertex_x0,
  input  logic signed [COORD_W-1:0] vertex_y0,
  input  logic signed [COORD_W-1:0] vertex_x1,
  input  logic signed [COORD_W-1:0] vertex_y1,
  input  logic signed [COORD_W-1:0] vertex_x2,
  input  logic signed [COORD_W-1:0] vertex_y2,
  input  logic signed [COORD_W-1:0] vertex_x3,
  input  logic signed [COORD_W-1:0] vertex_y3,
  output logic                      pt_valid,
  input  logic                      pt_ready,
  output lat_pt_t                   pt
);

  logic [LAT_STAGES-1:0] v;
  logic [LAT_STAGES-1:0] vin;
  logic [LAT_STAGES:0]   rdy;

  logic signed [COORD_W-1:0] vtx [2][4];

  // Stage registers, one entry per axis.
  logic signed [SUM_W-1:0]   s1_sum [2];
  logic                      s1_quad;
  logic [SUM_W-1:0]          s2_u [2];
  logic signed [COORD_W-1:0] s2_cq [2];
  logic                      s2_quad;
  logic [QHI_W-1:0]          s3_qhi [2];
  logic [HALF_W-1:0]         s3_hi [2];
  logic [HALF_W-1:0]         s3_lo [2];
  logic signed [COORD_W-1:0] s3_cq [2];
  logic                      s3_quad;
  logic [QHI_W-1:0]          s4_qhi [2];
  logic [HALF_W-1:0]         s4_qlo [2];
  logic signed [COORD_W-1:0] s4_cq [2];
  logic                      s4_quad;
  logic signed [COORD_W:0]   s5_diff [2];
  logic [COORD_W-1:0]        s6_cell [2];
  logic                      s6_neg [2];

  // Combinational next values.
  logic signed [SUM_W-1:0]     sum_next [2];
  logic [2*HALF_W:0]           prod_hi [2];
  logic [HALF_W-1:0]           rem_wide [2];
  logic [HALF_W+1:0]           lo_num [2];
  logic [DIVLO_W+DIVLO_W:0]    prod_lo [2];
  logic [QHI_W+HALF_W-1:0]     tri_f [2];
  logic signed [COORD_W-1:0]   cen [2];
  logic signed [COORD_W-1:0]   box_min [2];
  logic [2*COORD_W-1:0]        prod_sc [2];
  logic [LATTICE_BITS-1:0]     coord_next [2];
  logic                        clamp_next [2];

  assign vtx[0][0] = vertex_x0;
  assign vtx[0][1] = vertex_x1;
  assign vtx[0][2] = vertex_x2;
  assign vtx[0][3] = vertex_x3;
  assign vtx[1][0] = vertex_y0;
  assign vtx[1][1] = vertex_y1;
  assign vtx[1][2] = vertex_y2;
  assign vtx[1][3] = vertex_y3;

  assign box_min[0] = cfg.min_x;
  assign box_min[1] = cfg.min_y;

  always_comb begin
    rdy[LAT_STAGES] = pt_ready;
    for (int k = LAT_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
    vin[0] = in_valid;
    for (int k = 1; k < LAT_STAGES; k++) begin
      vin[k] = v[k-1];
    end
  end

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      sum_next[a] = SUM_W'(vtx[a][0]) + SUM_W'(vtx[a][1]) + SUM_W'(vtx[a][2])
                  + (cfg.quad ? SUM_W'(vtx[a][3]) : SUM_W'(0));
      // Upper half of the biased sum divided by three via its reciprocal.
      prod_hi[a] = $bits(prod_hi[a])'(s2_u[a][SUM_W-1:HALF_W])
                 * $bits(prod_hi[a])'(DIV3_HI_MUL);
      // Remainder of the upper half carries into the lower half.
      rem_wide[a] = s3_hi[a] - (HALF_W'(s3_qhi[a]) + {s3_qhi[a], 1'b0});
      lo_num[a] = {rem_wide[a][1:0], s3_lo[a]};
      prod_lo[a] = $bits(prod_lo[a])'(lo_num[a]) * $bits(prod_lo[a])'(DIV3_LO_MUL);
      // The quotient of the biased sum is offset by 2^31, so flip the sign bit.
      tri_f[a] = {s4_qhi[a], s4_qlo[a]};
      cen[a] = s4_quad ? s4_cq[a] : {~tri_f[a][COORD_W-1], tri_f[a][COORD_W-2:0]};
      prod_sc[a] = (2*COORD_W)'(s5_diff[a][COORD_W-1:0]) * (2*COORD_W)'(cfg.scale);
      if (s6_neg[a]) begin
        coord_next[a] = '0;
        clamp_next[a] = 1'b1;
      end else if (s6_cell[a] > CELL_TOP) begin
        coord_next[a] = '1;
        clamp_next[a] = 1'b1;
      end else begin
        coord_next[a] = s6_cell[a][LATTICE_BITS-1:0];
        clamp_next[a] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < LAT_STAGES; k++) begin
        if (rdy[k]) v[k] <= vin[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_quad <= cfg.quad;
      for (int a = 0; a < 2; a++) s1_sum[a] <= sum_next[a];
    end
    if (rdy[1]) begin
      s2_quad <= s1_quad;
      for (int a = 0; a < 2; a++) begin
        s2_u[a]  <= $unsigned(s1_sum[a]) + TRI_BIAS;
        s2_cq[a] <= s1_sum[a][SUM_W-1:2];
      end
    end
    if (rdy[2]) begin
      s3_quad <= s2_quad;
      for (int a = 0; a < 2; a++) begin
        s3_qhi[a] <= prod_hi[a][DIVHI_SH+QHI_W-1:DIVHI_SH];
        s3_hi[a]  <= s2_u[a][SUM_W-1:HALF_W];
        s3_lo[a]  <= s2_u[a][HALF_W-1:0];
        s3_cq[a]  <= s2_cq[a];
      end
    end
    if (rdy[3]) begin
      s4_quad <= s3_quad;
      for (int a = 0; a < 2; a++) begin
        s4_qhi[a] <= s3_qhi[a];
        s4_qlo[a] <= prod_lo[a][DIVLO_SH+HALF_W-1:DIVLO_SH];
        s4_cq[a]  <= s3_cq[a];
      end
    end
    if (rdy[4]) begin
      for (int a = 0; a < 2; a++) begin
        s5_diff[a] <= (COORD_W+1)'(cen[a]) - (COORD_W+1)'(box_min[a]);
      end
    end
    if (rdy[5]) begin
      for (int a = 0; a < 2; a++) begin
        s6_cell[a] <= prod_sc[a][2*COORD_W-1:COORD_W];
        s6_neg[a]  <= s5_diff[a][COORD_W];
      end
    end
    if (rdy[6]) begin
      pt.x       <= coord_next[0];
      pt.y       <= coord_next[1];
      pt.clamped <= clamp_next[0] | clamp_next[1];
    end
  end

  assign in_ready = rdy[0];
  assign pt_valid = v[LAT_STAGES-1];

endmodule

@@ rtl/echk_hilbert.sv @@
module echk_hilbert import echk_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               pt_valid,
  output logic               pt_ready,
  input  lat_pt_t            pt,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CURVE_W-1:0] curve_index,
  output logic               clamped
);

  localparam int DIST_W = 2 * LATTICE_BITS;

  logic [HIL_STAGES-1:0] v;
  logic [HIL_STAGES-1:0] vin;
  logic [HIL_STAGES:0]   rdy;

  logic [LATTICE_BITS-1:0] xq [HIL_STAGES];
  logic [LATTICE_BITS-1:0] yq [HIL_STAGES];
  logic [DIST_W-1:0]       dq [HIL_STAGES];
  logic                    cq [HIL_STAGES];
  logic [LATTICE_BITS-1:0] xn [HIL_STAGES];
  logic [LATTICE_BITS-1:0] yn [HIL_STAGES];
  logic [DIST_W-1:0]       dn [HIL_STAGES];
  logic                    cin [HIL_STAGES];

  logic [LATTICE_BITS-1:0] xs;
  logic [LATTICE_BITS-1:0] ys;
  logic [LATTICE_BITS-1:0] swap;
  logic [DIST_W-1:0]       ds;
  logic                    rx;
  logic                    ry;
  int                      bi;

  always_comb begin
    rdy[HIL_STAGES] = out_ready;
    for (int k = HIL_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
    vin[0] = pt_valid;
    cin[0] = pt.clamped;
    for (int k = 1; k < HIL_STAGES; k++) begin
      vin[k] = v[k-1];
      cin[k] = cq[k-1];
    end
  end

  // Each stage resolves a group of curve levels, most significant first.
  // A level contributes two distance bits and may rotate the quadrant.
  always_comb begin
    xs = '0;
    ys = '0;
    ds = '0;
    swap = '0;
    rx = 1'b0;
    ry = 1'b0;
    bi = 0;
    for (int k = 0; k < HIL_STAGES; k++) begin
      if (k == 0) begin
        xs = pt.x;
        ys = pt.y;
        ds = '0;
      end else begin
        xs = xq[k-1];
        ys = yq[k-1];
        ds = dq[k-1];
      end
      for (int j = 0; j < HIL_STEPS; j++) begin
        bi = LATTICE_BITS - 1 - k * HIL_STEPS - j;
        if (bi >= 0) begin
          rx = xs[bi];
          ry = ys[bi];
          ds[2*bi +: 2] = {rx, rx ^ ry};
          if (!ry) begin
            if (rx) begin
              xs = ~xs;
              ys = ~ys;
            end
            swap = xs;
            xs = ys;
            ys = swap;
          end
        end
      end
      xn[k] = xs;
      yn[k] = ys;
      dn[k] = ds;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < HIL_STAGES; k++) begin
        if (rdy[k]) v[k] <= vin[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < HIL_STAGES; k++) begin
      if (rdy[k]) begin
        xq[k] <= xn[k];
        yq[k] <= yn[k];
        dq[k] <= dn[k];
        cq[k] <= cin[k];
      end
    end
  end

  assign pt_ready    = rdy[0];
  assign out_valid   = v[HIL_STAGES-1];
  assign curve_index = CURVE_W'(dq[HIL_STAGES-1]);
  assign clamped     = cq[HIL_STAGES-1];

endmodule

@@ rtl/element_centroid_hilbert_key.sv @@
// Maps each mesh element (three or four Q16.16 vertices) to the Hilbert curve
// distance of its centroid's lattice cell, plus a flag that is set when the
// centroid fell outside the lattice and was saturated. The block is fully
// pipelined: it takes one element per clock while the output is not stalled.
// Seven stages form the centroid, the exact division by three for triangles,
// the box offset, the scale multiply and the saturation; four stages walk the
// curve levels, up to four levels per stage.
// Every stage has its own ready, so empty stages keep filling while the
// output waits, and up to 11 elements can be held in flight. Registers are
// written through the configuration channel, which is always ready, and must
// only be changed while no element is in the pipeline.
module element_centroid_hilbert_key import echk_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [COORD_W-1:0]        cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] vertex_x0,
  input  logic signed [COORD_W-1:0] vertex_y0,
  input  logic signed [COORD_W-1:0] vertex_x1,
  input  logic signed [COORD_W-1:0] vertex_y1,
  input  logic signed [COORD_W-1:0] vertex_x2,
  input  logic signed [COORD_W-1:0] vertex_y2,
  input  logic signed [COORD_W-1:0] vertex_x3,
  input  logic signed [COORD_W-1:0] vertex_y3,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [CURVE_W-1:0]        curve_index,
  output logic                      clamped
);

  logic [VCNT_W-1:0]         vertices_used;
  logic signed [COORD_W-1:0] box_min_x;
  logic signed [COORD_W-1:0] box_min_y;
  logic [COORD_W-1:0]        lattice_scale;
  cfg_t                      cfg;

  logic    pt_valid;
  logic    pt_ready;
  lat_pt_t pt;

  logic [FLIGHT_W-1:0] in_flight;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertices_used <= VERTICES_RESET;
      box_min_x     <= '0;
      box_min_y     <= '0;
      lattice_scale <= SCALE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_VERTICES_USED: vertices_used <= cfg_data[VCNT_W-1:0];
        REG_BOX_MIN_X:     box_min_x     <= cfg_data;
        REG_BOX_MIN_Y:     box_min_y     <= cfg_data;
        REG_LATTICE_SCALE: lattice_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  // Any count other than three averages four vertices.
  assign cfg.quad  = (vertices_used != VERTICES_TRI);
  assign cfg.min_x = box_min_x;
  assign cfg.min_y = box_min_y;
  assign cfg.scale = lattice_scale;

  echk_lattice u_lattice (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .vertex_x0 (vertex_x0),
    .vertex_y0 (vertex_y0),
    .vertex_x1 (vertex_x1),
    .vertex_y1 (vertex_y1),
    .vertex_x2 (vertex_x2),
    .vertex_y2 (vertex_y2),
    .vertex_x3 (vertex_x3),
    .vertex_y3 (vertex_y3),
    .pt_valid  (pt_valid),
    .pt_ready  (pt_ready),
    .pt        (pt)
  );

  echk_hilbert u_hilbert (
    .clk         (clk),
    .rst         (rst),
    .pt_valid    (pt_valid),
    .pt_ready    (pt_ready),
    .pt          (pt),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .curve_index (curve_index),
    .clamped     (clamped)
  );

  // Number of elements accepted whose key has not yet been taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else begin
      in_flight <= in_flight + FLIGHT_W'(in_valid && in_ready)
                             - FLIGHT_W'(out_valid && out_ready);
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    in_flight <= FLIGHT_W'(PIPE_DEPTH))
    else $error("more elements in flight than pipeline stages");

  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> in_flight == FLIGHT_W'(PIPE_DEPTH))
    else $error("input stalled while the pipeline has room");

  assert property (@(posedge clk) disable iff (rst)
    in_flight == '0 |-> !out_valid)
    else $error("key presented with no element in flight");

endmodule
